@@ design/awvn_pkg.sv @@
// Package for the area-weighted vertex normal block: field widths, command codes
// and the saturating accumulator add. It has no dependencies.
`timescale 1ns / 1ps

package awvn_pkg;

    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int FRAC_BITS_DEF    = 20;

    localparam int IDX_W   = 12;
    localparam int POS_W   = 24;
    localparam int EDGE_W  = 25;
    localparam int ACC_W   = 40;
    localparam int OUT_W   = 18;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 64;
    localparam int CR_W    = 51;
    localparam int H_W     = 52;
    localparam int MAG_W   = 30;
    localparam int SQ_W    = 62;
    localparam int ROOT_W  = 32;
    localparam int QUO_W   = 17;
    localparam int NUM_W   = 47;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TRI  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    localparam logic signed [H_W:0] SUM_MAX =
        {{(H_W - ACC_W + 2){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [H_W:0] SUM_MIN =
        {{(H_W - ACC_W + 2){1'b1}}, {(ACC_W - 1){1'b0}}};

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [H_W-1:0]   h
    );
        logic signed [H_W:0] s;
        s = (H_W + 1)'(a) + (H_W + 1)'(h);
        if (s > SUM_MAX) begin
            return SUM_MAX[ACC_W-1:0];
        end else if (s < SUM_MIN) begin
            return SUM_MIN[ACC_W-1:0];
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

@@ design/awvn_cmd_if.sv @@
// Command channel: valid/ready handshake with the command and its operands.
// Depends on awvn_pkg for field widths.
`timescale 1ns / 1ps

interface awvn_cmd_if;
    import awvn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic [IDX_W-1:0]        third_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    modport source (output valid, command, first_index, second_index, third_index,
                    pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, command, first_index, second_index, third_index,
                    pos_x, pos_y, pos_z, output ready);
endinterface

@@ design/awvn_nrm_if.sv @@
// Result channel: valid/ready handshake with one normalized vertex normal.
// Depends on awvn_pkg for field widths.
`timescale 1ns / 1ps

interface awvn_nrm_if;
    import awvn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    zero_length;

    modport source (output valid, normal_x, normal_y, normal_z, zero_length,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, zero_length,
                    output ready);
endinterface

@@ design/awvn_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on awvn_pkg for operand and product widths.
`timescale 1ns / 1ps

module awvn_mul (
    input  logic                             i_clk,
    input  logic signed [awvn_pkg::MUL_W-1:0]  i_a,
    input  logic signed [awvn_pkg::MUL_W-1:0]  i_b,
    output logic signed [awvn_pkg::PROD_W-1:0] o_p
);
    import awvn_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

@@ design/awvn_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on awvn_pkg for widths and the step count.
`timescale 1ns / 1ps

module awvn_isqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [awvn_pkg::SQ_W-1:0]        i_n,
    output logic                             o_done,
    output logic [awvn_pkg::ROOT_W-1:0]      o_root
);
    import awvn_pkg::*;

    logic [63:0] r_n, r_res, r_bit;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [63:0] trial_sum;

    assign trial_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= 64'(i_n);
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
                r_cnt  <= 6'(SQRT_STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_n >= trial_sum) begin
                    r_n   <= r_n - trial_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];
endmodule

@@ design/awvn_div.sv @@
// Restoring divider, one quotient bit per cycle; the quotient is known to fit
// in QUO_W bits. Depends on awvn_pkg for widths.
`timescale 1ns / 1ps

module awvn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [awvn_pkg::NUM_W-1:0]    i_num,
    input  logic [awvn_pkg::ROOT_W-1:0]   i_den,
    output logic                          o_done,
    output logic [awvn_pkg::QUO_W-1:0]    o_quo
);
    import awvn_pkg::*;

    logic [ROOT_W-1:0] r_rem, r_den;
    logic [QUO_W-1:0]  r_num, r_quo;
    logic [4:0]        r_cnt;
    logic              r_busy, r_done;
    logic [ROOT_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_num[QUO_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= ROOT_W'(i_num[NUM_W-1:QUO_W]);
                r_num  <= i_num[QUO_W-1:0];
                r_den  <= i_den;
                r_quo  <= '0;
                r_cnt  <= 5'(QUO_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? ROOT_W'(trial - {1'b0, r_den}) : trial[ROOT_W-1:0];
                r_quo  <= {r_quo[QUO_W-2:0], fits};
                r_num  <= r_num << 1;
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ design/area_weighted_vertex_normals.sv @@
// Area-weighted vertex normals: the sequencer, position and accumulator memories.
// Depends on awvn_pkg, awvn_cmd_if, awvn_nrm_if, awvn_mul, awvn_isqrt, awvn_div.
//
// Usage: commands arrive on i_cmd (valid/ready). A load writes a vertex position
// and clears its accumulator; a triangle adds half the edge cross product into the
// accumulators of its three corners; a read returns the unit-length sum on o_nrm.
// Only reads produce a transfer on o_nrm; a zero sum or an out-of-range index
// gives zero normals with zero_length set.
// After reset the accumulator memory is cleared, one row a cycle; i_cmd.ready
// stays low meanwhile. One command is worked at a time and i_cmd.ready is low
// while it runs. A load is written as it is accepted. A triangle makes three
// position reads, six products through the one shared multiplier, and three
// accumulator read-modify-writes on the single-port memory. A read goes through
// the memory read and check, up to 29 normalizing shifts (one bit a cycle), three
// squares, 32 square root steps and three 17-step divisions, then the hand-off to
// the output register. A zero sum goes from the check straight to the output, and
// an out-of-range read straight from idle. Results sit in an output register; the
// next command is taken while a result waits, and a second read stalls only at
// its output step until o_nrm drains.
`timescale 1ns / 1ps

module area_weighted_vertex_normals #(
    parameter int VERTEX_COUNT = awvn_pkg::VERTEX_COUNT_DEF,
    parameter int FRAC_BITS    = awvn_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    awvn_cmd_if.sink   i_cmd,
    awvn_nrm_if.source o_nrm
);
    import awvn_pkg::*;

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TP0, S_TP1, S_TP2, S_TP3, S_MUL, S_ACRD, S_ACWR,
        S_RRD, S_RCHK, S_NORM, S_SQ, S_SQRT, S_DIV, S_EMIT
    } t_state;

    t_state r_state;

    logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
    logic [3*ACC_W-1:0] acc_mem [VERTEX_COUNT];
    logic [3*POS_W-1:0] r_pos_rd;
    logic [3*ACC_W-1:0] r_acc_rd;

    logic [AW-1:0]               r_clr, r_a, r_b, r_c;
    logic signed [POS_W-1:0]     r_pa [3];
    logic signed [EDGE_W-1:0]    r_u [3];
    logic signed [EDGE_W-1:0]    r_v [3];
    logic [2:0]                  r_step;
    logic [1:0]                  r_corner;
    logic signed [CR_W-1:0]      r_cr;
    logic signed [H_W-1:0]       r_h [3];
    logic [ACC_W-1:0]            r_m [3];
    logic                        r_sgn [3];
    logic [SQ_W-1:0]             r_sq;
    logic [ROOT_W-1:0]           r_len;
    logic [QUO_W-1:0]            r_q [3];
    logic                        r_zero;
    logic                        r_ov;
    logic signed [OUT_W-1:0]     r_nx, r_ny, r_nz;
    logic                        r_nzl;

    // Command decode
    logic          accept;
    logic [AW-1:0] in_a, in_b, in_c;
    logic          ok_a, ok_b, ok_c;
    assign accept = i_cmd.valid && i_cmd.ready;
    assign in_a = AW'(i_cmd.first_index);
    assign in_b = AW'(i_cmd.second_index);
    assign in_c = AW'(i_cmd.third_index);
    assign ok_a = 32'(i_cmd.first_index) < VERTEX_COUNT;
    assign ok_b = 32'(i_cmd.second_index) < VERTEX_COUNT;
    assign ok_c = 32'(i_cmd.third_index) < VERTEX_COUNT;
    assign i_cmd.ready = (r_state == S_IDLE);

    // Memory address and write control
    logic [AW-1:0]      corner_idx, pos_addr, acc_addr;
    logic               pos_we, acc_we;
    logic [3*ACC_W-1:0] acc_wdata;
    logic signed [ACC_W-1:0] acc_old [3];

    always_comb begin
        case (r_corner)
            2'd0:    corner_idx = r_a;
            2'd1:    corner_idx = r_b;
            default: corner_idx = r_c;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_old[i] = r_acc_rd[i*ACC_W +: ACC_W];
        end
    end

    always_comb begin
        pos_addr  = in_a;
        acc_addr  = in_a;
        pos_we    = 1'b0;
        acc_we    = 1'b0;
        acc_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                acc_addr = r_clr;
                acc_we   = 1'b1;
            end
            S_IDLE: begin
                pos_we = accept && (i_cmd.command == CMD_LOAD) && ok_a;
                acc_we = pos_we;
            end
            S_TP0:  pos_addr = r_a;
            S_TP1:  pos_addr = r_b;
            S_TP2:  pos_addr = r_c;
            S_ACRD: acc_addr = corner_idx;
            S_ACWR: begin
                acc_addr  = corner_idx;
                acc_we    = 1'b1;
                acc_wdata = {sat_add(acc_old[2], r_h[2]), sat_add(acc_old[1], r_h[1]),
                             sat_add(acc_old[0], r_h[0])};
            end
            S_RRD:  acc_addr = r_a;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_addr] <= {i_cmd.pos_z, i_cmd.pos_y, i_cmd.pos_x};
        end
        r_pos_rd <= pos_mem[pos_addr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_addr] <= acc_wdata;
        end
        r_acc_rd <= acc_mem[acc_addr];
    end

    // Shared multiplier operands
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                3'd0: begin mul_a = MUL_W'(r_u[1]); mul_b = MUL_W'(r_v[2]); end
                3'd1: begin mul_a = MUL_W'(r_u[2]); mul_b = MUL_W'(r_v[1]); end
                3'd2: begin mul_a = MUL_W'(r_u[2]); mul_b = MUL_W'(r_v[0]); end
                3'd3: begin mul_a = MUL_W'(r_u[0]); mul_b = MUL_W'(r_v[2]); end
                3'd4: begin mul_a = MUL_W'(r_u[0]); mul_b = MUL_W'(r_v[1]); end
                3'd5: begin mul_a = MUL_W'(r_u[1]); mul_b = MUL_W'(r_v[0]); end
                default: ;
            endcase
        end else if (r_state == S_SQ && r_step < 3'd3) begin
            mul_a = $signed({2'b00, r_m[r_step[1:0]][MAG_W-1:0]});
            mul_b = mul_a;
        end
    end

    awvn_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Cross component finish: halve and rescale with round half up
    logic signed [CR_W-1:0] p_cr, c_diff;
    logic signed [H_W-1:0]  c_ext, h_new;
    assign p_cr   = CR_W'(mul_p);
    assign c_diff = r_cr - p_cr;
    assign c_ext  = H_W'(c_diff) + (H_W'(1) << FRAC_BITS);
    assign h_new  = c_ext >>> (FRAC_BITS + 1);

    // Square root and divider
    logic              sqrt_start, sqrt_done, div_start, div_done;
    logic [ROOT_W-1:0] root;
    logic [QUO_W-1:0]  quo;
    logic [NUM_W-1:0]  div_num;

    assign sqrt_start = (r_state == S_SQRT) && (r_step == 3'd0);
    assign div_start  = (r_state == S_DIV) && (r_step == 3'd0);
    assign div_num    = {1'b0, r_m[r_corner][MAG_W-1:0], 16'd0}
                        + NUM_W'(r_len >> 1);

    awvn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_n     (r_sq),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    awvn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_len),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // Normalizing tests: any magnitude at or above 2^30, all below 2^29
    logic any_high, all_low;
    always_comb begin
        any_high = 1'b0;
        all_low  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (r_m[i][ACC_W-1:MAG_W] != '0) any_high = 1'b1;
            if (r_m[i][ACC_W-1:MAG_W-1] != '0) all_low = 1'b0;
        end
    end

    logic signed [OUT_W-1:0] q_signed [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_signed[i] = r_sgn[i] ? -OUT_W'({1'b0, r_q[i]}) : OUT_W'({1'b0, r_q[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_step   <= '0;
            r_corner <= '0;
            r_zero   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && o_nrm.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(VERTEX_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_a      <= in_a;
                    r_b      <= in_b;
                    r_c      <= in_c;
                    r_step   <= '0;
                    r_corner <= '0;
                    r_zero   <= 1'b0;
                    if (accept) begin
                        case (i_cmd.command)
                            CMD_TRI: begin
                                if (ok_a && ok_b && ok_c) r_state <= S_TP0;
                            end
                            CMD_READ: begin
                                if (ok_a) begin
                                    r_state <= S_RRD;
                                end else begin
                                    r_zero  <= 1'b1;
                                    r_state <= S_EMIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_TP0: r_state <= S_TP1;
                S_TP1: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pa[i] <= r_pos_rd[i*POS_W +: POS_W];
                    end
                    r_state <= S_TP2;
                end
                S_TP2: begin
                    for (int i = 0; i < 3; i++) begin
                        r_u[i] <= EDGE_W'($signed(r_pos_rd[i*POS_W +: POS_W]))
                                  - EDGE_W'(r_pa[i]);
                    end
                    r_state <= S_TP3;
                end
                S_TP3: begin
                    for (int i = 0; i < 3; i++) begin
                        r_v[i] <= EDGE_W'($signed(r_pos_rd[i*POS_W +: POS_W]))
                                  - EDGE_W'(r_pa[i]);
                    end
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // Even products start a component, odd products finish it.
                    if (r_step != 3'd0) begin
                        if (r_step[0]) begin
                            r_cr <= p_cr;
                        end else begin
                            r_h[2'((r_step - 3'd1) >> 1)] <= h_new;
                        end
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd6) begin
                        r_corner <= '0;
                        r_state  <= S_ACRD;
                    end
                end
                S_ACRD: r_state <= S_ACWR;
                S_ACWR: begin
                    r_corner <= r_corner + 2'd1;
                    r_state  <= (r_corner == 2'd2) ? S_IDLE : S_ACRD;
                end
                S_RRD: r_state <= S_RCHK;
                S_RCHK: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sgn[i] <= acc_old[i][ACC_W-1];
                        r_m[i]   <= acc_old[i][ACC_W-1] ? ACC_W'(-acc_old[i])
                                                        : ACC_W'(acc_old[i]);
                    end
                    if (r_acc_rd == '0) begin
                        r_zero  <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    r_step <= '0;
                    if (any_high) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (all_low) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_step == 3'd1) begin
                        r_sq <= mul_p[SQ_W-1:0];
                    end else if (r_step != 3'd0) begin
                        r_sq <= r_sq + mul_p[SQ_W-1:0];
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd3) begin
                        r_step  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_step <= 3'd1;
                    if (sqrt_done) begin
                        r_len    <= root;
                        r_step   <= '0;
                        r_corner <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= 3'd1;
                    if (div_done) begin
                        r_q[r_corner] <= quo;
                        r_step        <= '0;
                        r_corner      <= r_corner + 2'd1;
                        if (r_corner == 2'd2) r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || o_nrm.ready) begin
                        r_ov    <= 1'b1;
                        r_nzl   <= r_zero;
                        r_nx    <= r_zero ? '0 : q_signed[0];
                        r_ny    <= r_zero ? '0 : q_signed[1];
                        r_nz    <= r_zero ? '0 : q_signed[2];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_nrm.valid       = r_ov;
    assign o_nrm.normal_x    = r_nx;
    assign o_nrm.normal_y    = r_ny;
    assign o_nrm.normal_z    = r_nz;
    assign o_nrm.zero_length = r_nzl;
endmodule
